[hw/rtl/mtok_pkg.sv]
// ----------------------------------------------------------------------------
// mtok_pkg
// shared types, character codes and helper functions of the markup tokenizer
// ----------------------------------------------------------------------------
package mtok_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_ESCAPE
    } mode_t;

    localparam logic [3:0] KIND_DOT       = 4'd0;
    localparam logic [3:0] KIND_LBRACE    = 4'd1;
    localparam logic [3:0] KIND_SEMICOLON = 4'd2;
    localparam logic [3:0] KIND_LBRACKET  = 4'd3;
    localparam logic [3:0] KIND_RBRACKET  = 4'd4;
    localparam logic [3:0] KIND_STRING    = 4'd5;
    localparam logic [3:0] KIND_COLON     = 4'd6;
    localparam logic [3:0] KIND_RBRACE    = 4'd7;
    localparam logic [3:0] KIND_NUMBER    = 4'd8;
    localparam logic [3:0] KIND_IDENT     = 4'd9;
    localparam logic [3:0] KIND_UNKNOWN   = 4'd10;
    localparam logic [3:0] KIND_UNTERM    = 4'd11;
    localparam logic [3:0] KIND_END       = 4'd12;

    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [15:0] START_CAP = 16'hFFFF;

    // result queue
    localparam int QDEPTH = 4;
    localparam int CNT_W  = 3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [16:0] length;
        logic        run_last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [15:0] sat_start(input logic [16:0] v);
        return v[16] ? START_CAP : v[15:0];
    endfunction

    function automatic logic [16:0] span_len(input logic [16:0] end_pos,
                                             input logic [15:0] origin);
        return (end_pos > {1'b0, origin}) ? end_pos - {1'b0, origin} : 17'd0;
    endfunction

    // {hit, kind} for the single-character punctuation tokens
    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        unique case (c)
            CH_DOT:       r = {1'b1, KIND_DOT};
            CH_LBRACE:    r = {1'b1, KIND_LBRACE};
            CH_SEMICOLON: r = {1'b1, KIND_SEMICOLON};
            CH_LBRACKET:  r = {1'b1, KIND_LBRACKET};
            CH_RBRACKET:  r = {1'b1, KIND_RBRACKET};
            CH_COLON:     r = {1'b1, KIND_COLON};
            CH_RBRACE:    r = {1'b1, KIND_RBRACE};
            default:      r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic token_t make_token(input logic [3:0] kind, input logic [15:0] start,
                                          input logic [16:0] length);
        token_t t;
        t.kind     = kind;
        t.start    = start;
        t.length   = length;
        t.run_last = 1'b0;
        return t;
    endfunction

endpackage

[hw/rtl/mtok_if.sv]
// ----------------------------------------------------------------------------
// mtok_if
// valid/ready channels of the markup tokenizer: source bytes in, tokens out
// ----------------------------------------------------------------------------
interface mtok_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       final_byte;

    modport source (output valid, output source_byte, output final_byte, input ready);
    modport sink   (input valid, input source_byte, input final_byte, output ready);
endinterface

interface mtok_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [16:0] token_length;
    logic        run_last;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output run_last, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input run_last, output ready);
endinterface

[hw/rtl/markup_tokenizer.sv]
// ----------------------------------------------------------------------------
// markup_tokenizer
// streaming tokenizer: one source byte per word in, one token per word out
// ----------------------------------------------------------------------------
// src carries source bytes; final_byte marks the last byte of a source, which
// flushes any pending token and adds an end token, then the scanner restarts.
// tok carries tokens as kind, start offset and length; run_last marks the last
// token caused by one byte. A byte causes zero to three tokens.
// A byte is taken into an input register, classified in the next cycle and
// its tokens are written into a four-entry result queue whose head drives tok.
// Throughput is one byte per cycle while each byte gives at most one token
// and tok does not stall; bytes with several tokens are held back by the
// single output port of the result queue.
// When tok stalls, the queue fills and src.ready drops once a byte's tokens
// no longer fit. Reset empties the queue and the input register and clears
// the position, the scan mode and the token origin.
// ----------------------------------------------------------------------------
module markup_tokenizer #(
    parameter int MAX_SOURCE_BYTES = 65536
) (
    input  logic                clk,
    input  logic                rst_n,
    mtok_byte_if.sink           src,
    mtok_token_if.source        tok
);

    localparam int POS_LIMIT = (MAX_SOURCE_BYTES < 65536) ? MAX_SOURCE_BYTES : 65536;
    localparam logic [17:0] POS_CAP = 18'(POS_LIMIT);

    // input register
    logic                      stage_valid_reg, stage_valid_next;
    logic [7:0]                byte_reg;
    logic                      last_reg;

    // scanner state
    mtok_pkg::mode_t           mode_reg, mode_next;
    logic [16:0]               position_reg, position_next;
    logic [15:0]               origin_reg, origin_next;

    // result queue
    mtok_pkg::token_t          q_reg  [mtok_pkg::QDEPTH];
    mtok_pkg::token_t          q_next [mtok_pkg::QDEPTH];
    logic [mtok_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    mtok_pkg::token_t          tok_v [3];
    logic [1:0]                n_v;
    mtok_pkg::mode_t           mode_v;
    logic [15:0]               origin_v;
    logic [16:0]               pos_v;

    logic                      pop;
    logic                      go;
    logic                      accept;
    logic [mtok_pkg::CNT_W-1:0] cnt_pop;

    // token generation for the byte in the input register
    always_comb
    begin
        logic        do_class;
        logic [4:0]  pk;
        logic [17:0] p_inc;
        mode_v   = mode_reg;
        origin_v = origin_reg;
        n_v      = 2'd0;
        do_class = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            tok_v[k] = '0;
        end

        unique case (mode_reg)
            mtok_pkg::MODE_IDENT:
            begin
                if (!mtok_pkg::is_alpha(byte_reg) && !mtok_pkg::is_digit(byte_reg))
                begin
                    tok_v[n_v] = mtok_pkg::make_token(mtok_pkg::KIND_IDENT, origin_reg,
                        mtok_pkg::span_len(position_reg, origin_reg));
                    n_v = n_v + 2'd1;
                    mode_v = mtok_pkg::MODE_IDLE;
                    do_class = 1'b1;
                end
            end
            mtok_pkg::MODE_NUMBER:
            begin
                if (!mtok_pkg::is_digit(byte_reg))
                begin
                    tok_v[n_v] = mtok_pkg::make_token(mtok_pkg::KIND_NUMBER, origin_reg,
                        mtok_pkg::span_len(position_reg, origin_reg));
                    n_v = n_v + 2'd1;
                    mode_v = mtok_pkg::MODE_IDLE;
                    do_class = 1'b1;
                end
            end
            mtok_pkg::MODE_STRING:
            begin
                if (byte_reg == mtok_pkg::CH_BACKSLASH)
                begin
                    mode_v = mtok_pkg::MODE_ESCAPE;
                end
                else if (byte_reg == mtok_pkg::CH_QUOTE)
                begin
                    tok_v[n_v] = mtok_pkg::make_token(mtok_pkg::KIND_STRING, origin_reg,
                        mtok_pkg::span_len(position_reg, origin_reg));
                    n_v = n_v + 2'd1;
                    mode_v = mtok_pkg::MODE_IDLE;
                end
            end
            mtok_pkg::MODE_ESCAPE:
            begin
                mode_v = mtok_pkg::MODE_STRING;
            end
            default:
            begin
                mode_v = mtok_pkg::MODE_IDLE;
                do_class = 1'b1;
            end
        endcase

        // classify a byte seen between tokens
        pk = mtok_pkg::punct_kind(byte_reg);
        if (do_class)
        begin
            priority if (pk[4])
            begin
                tok_v[n_v] = mtok_pkg::make_token(pk[3:0],
                    mtok_pkg::sat_start(position_reg), 17'd1);
                n_v = n_v + 2'd1;
            end
            else if (byte_reg == mtok_pkg::CH_QUOTE)
            begin
                mode_v   = mtok_pkg::MODE_STRING;
                origin_v = mtok_pkg::sat_start(position_reg + 17'd1);
            end
            else if (mtok_pkg::is_digit(byte_reg))
            begin
                mode_v   = mtok_pkg::MODE_NUMBER;
                origin_v = mtok_pkg::sat_start(position_reg);
            end
            else if (mtok_pkg::is_alpha(byte_reg))
            begin
                mode_v   = mtok_pkg::MODE_IDENT;
                origin_v = mtok_pkg::sat_start(position_reg);
            end
            else if (!mtok_pkg::is_space(byte_reg))
            begin
                tok_v[n_v] = mtok_pkg::make_token(mtok_pkg::KIND_UNKNOWN,
                    mtok_pkg::sat_start(position_reg), 17'd1);
                n_v = n_v + 2'd1;
            end
        end

        // saturating position
        p_inc = {1'b0, position_reg} + 18'd1;
        pos_v = (p_inc > POS_CAP) ? POS_CAP[16:0] : p_inc[16:0];

        // end of source: flush pending token and close with an end token
        if (last_reg)
        begin
            unique case (mode_v)
                mtok_pkg::MODE_IDENT:
                begin
                    tok_v[n_v] = mtok_pkg::make_token(mtok_pkg::KIND_IDENT, origin_v,
                        mtok_pkg::span_len(pos_v, origin_v));
                    n_v = n_v + 2'd1;
                end
                mtok_pkg::MODE_NUMBER:
                begin
                    tok_v[n_v] = mtok_pkg::make_token(mtok_pkg::KIND_NUMBER, origin_v,
                        mtok_pkg::span_len(pos_v, origin_v));
                    n_v = n_v + 2'd1;
                end
                mtok_pkg::MODE_STRING, mtok_pkg::MODE_ESCAPE:
                begin
                    tok_v[n_v] = mtok_pkg::make_token(mtok_pkg::KIND_UNTERM, origin_v,
                        mtok_pkg::span_len(pos_v, origin_v));
                    n_v = n_v + 2'd1;
                end
                default:
                begin
                end
            endcase
            tok_v[n_v] = mtok_pkg::make_token(mtok_pkg::KIND_END,
                mtok_pkg::sat_start(pos_v), 17'd0);
            n_v = n_v + 2'd1;
            mode_v   = mtok_pkg::MODE_IDLE;
            origin_v = 16'd0;
            pos_v    = 17'd0;
        end

        if (n_v != 2'd0)
        begin
            tok_v[n_v - 2'd1].run_last = 1'b1;
        end
    end

    // handshakes and queue control
    assign pop     = (cnt_reg != '0) && tok.ready;
    assign cnt_pop = cnt_reg - {{(mtok_pkg::CNT_W-1){1'b0}}, pop};
    assign go      = stage_valid_reg
                     && ((cnt_pop + {1'b0, n_v}) <= mtok_pkg::CNT_W'(mtok_pkg::QDEPTH));
    assign src.ready = !stage_valid_reg || go;
    assign accept    = src.valid && src.ready;

    assign stage_valid_next = accept ? 1'b1 : (go ? 1'b0 : stage_valid_reg);
    assign mode_next        = go ? mode_v   : mode_reg;
    assign origin_next      = go ? origin_v : origin_reg;
    assign position_next    = go ? pos_v    : position_reg;
    assign cnt_next         = go ? cnt_pop + {1'b0, n_v} : cnt_pop;

    always_comb
    begin
        for (int i = 0; i < mtok_pkg::QDEPTH; i++)
        begin
            if (pop && (i < mtok_pkg::QDEPTH - 1))
            begin
                q_next[i] = q_reg[(i + 1) % mtok_pkg::QDEPTH];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            for (int k = 0; k < 3; k++)
            begin
                if (go && (2'(k) < n_v)
                    && ((cnt_pop + mtok_pkg::CNT_W'(k)) == mtok_pkg::CNT_W'(i)))
                begin
                    q_next[i] = tok_v[k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            mode_reg        <= mtok_pkg::MODE_IDLE;
            origin_reg      <= 16'd0;
            position_reg    <= 17'd0;
            cnt_reg         <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            mode_reg        <= mode_next;
            origin_reg      <= origin_next;
            position_reg    <= position_next;
            cnt_reg         <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= src.source_byte;
            last_reg <= src.final_byte;
        end
        for (int i = 0; i < mtok_pkg::QDEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    assign tok.valid        = (cnt_reg != '0);
    assign tok.token_kind   = q_reg[0].kind;
    assign tok.token_start  = q_reg[0].start;
    assign tok.token_length = q_reg[0].length;
    assign tok.run_last     = q_reg[0].run_last;

endmodule

[hw/rtl/mtok_checker.sv]
// ----------------------------------------------------------------------------
// mtok_checker
// port-level checks of the markup tokenizer, bound to markup_tokenizer
// ----------------------------------------------------------------------------
module mtok_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        tok_valid,
    input logic        tok_ready,
    input logic [3:0]  tok_kind,
    input logic [15:0] tok_start,
    input logic [16:0] tok_length,
    input logic        tok_run_last
);

    // a stalled token stays offered
    a_stall_valid: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid)
        else $error("token dropped while stalled");

    // a stalled token keeps its payload
    a_stall_data: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> $stable(tok_kind) && $stable(tok_start)
                                    && $stable(tok_length) && $stable(tok_run_last))
        else $error("token payload changed while stalled");

    // end token has zero length and closes its byte's run
    a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (tok_kind == mtok_pkg::KIND_END) |-> (tok_length == 17'd0) && tok_run_last)
        else $error("malformed end token");

    // dot, colon, left-brace and unknown tokens are one byte long
    a_punct_len: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && ((tok_kind == mtok_pkg::KIND_DOT) || (tok_kind == mtok_pkg::KIND_COLON)
                      || (tok_kind == mtok_pkg::KIND_UNKNOWN)
                      || (tok_kind == mtok_pkg::KIND_LBRACE)) |-> (tok_length == 17'd1))
        else $error("single-character token with wrong length");

endmodule

bind markup_tokenizer mtok_checker u_mtok_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tok_valid    (tok.valid),
    .tok_ready    (tok.ready),
    .tok_kind     (tok.token_kind),
    .tok_start    (tok.token_start),
    .tok_length   (tok.token_length),
    .tok_run_last (tok.run_last)
);
